// ===== rtl/spq_pkg.sv =====
// types and constants shared by the sorted priority queue modules
`default_nettype none
package spq_pkg;

   localparam int VALUE_W    = 32;
   localparam int REQ_PRI_W  = 8;
   localparam int STATUS_W   = 2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic                       mode;
      logic signed [VALUE_W-1:0]  value;
      logic [REQ_PRI_W-1:0]       priority_req;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic signed [VALUE_W-1:0]  removed_value;
      logic [REQ_PRI_W-1:0]       removed_priority;
   } rsp_type;

   typedef struct packed {
      logic                load_rsp;
      logic                do_insert;
      logic                do_remove;
      logic [STATUS_W-1:0] status;
   } ctl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== rtl/spq_ctrl.sv =====
// controller: handshake state, operation decode and status selection
`default_nettype none
module spq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_mode,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire spq_pkg::dp_stat_type dp_stat,
   output spq_pkg::ctl_cmd_type      cmd
);
   import spq_pkg::*;

   typedef enum logic [1:0] {
      ST_OPEN = 2'b01,
      ST_HOLD = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      req_xfer;

   assign req_ready = (state_ff == ST_OPEN) || rsp_ready;
   assign rsp_valid = (state_ff == ST_HOLD);
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      cmd           = '0;
      cmd.load_rsp  = req_xfer;
      if (req_mode == MODE_INSERT) begin
         cmd.do_insert = req_xfer && !dp_stat.full;
         cmd.status    = dp_stat.full ? STATUS_FULL : STATUS_INSERTED;
      end else begin
         cmd.do_remove = req_xfer && !dp_stat.empty;
         cmd.status    = dp_stat.empty ? STATUS_UNDERFLOW : STATUS_REMOVED;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_OPEN: begin
            if (req_xfer) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (req_xfer) state_in = ST_HOLD;
            else if (rsp_ready) state_in = ST_OPEN;
         end
         default: state_in = ST_OPEN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_OPEN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/spq_datapath.sv =====
// datapath: sorted entry row with parallel compare and shift, result register
`default_nettype none
module spq_datapath #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire spq_pkg::req_type     req_data,
   input  wire spq_pkg::ctl_cmd_type cmd,
   output spq_pkg::dp_stat_type      dp_stat,
   output spq_pkg::rsp_type          rsp_data
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [VALUE_W-1:0]  val_ff [CAPACITY];
   logic signed [VALUE_W-1:0]  val_in [CAPACITY];
   logic [PRIORITY_BITS-1:0]   pri_ff [CAPACITY];
   logic [PRIORITY_BITS-1:0]   pri_in [CAPACITY];
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CAPACITY-1:0]        ahead;
   logic [PRIORITY_BITS-1:0]   new_pri;
   logic [REQ_PRI_W-1:0]       front_pri;
   rsp_type                    rsp_ff, rsp_in;

   // priority width conversion in both directions
   for (genvar b = 0; b < PRIORITY_BITS; b++) begin : g_new_pri
      if (b < REQ_PRI_W) begin : g_bit
         assign new_pri[b] = req_data.priority_req[b];
      end else begin : g_zero
         assign new_pri[b] = 1'b0;
      end
   end

   for (genvar b = 0; b < REQ_PRI_W; b++) begin : g_front_pri
      if (b < PRIORITY_BITS) begin : g_bit
         assign front_pri[b] = pri_ff[0][b];
      end else begin : g_zero
         assign front_pri[b] = 1'b0;
      end
   end

   assign dp_stat.full  = (count_ff == CNT_W'(CAPACITY));
   assign dp_stat.empty = (count_ff == '0);

   for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
      // entry stays ahead of the new one
      assign ahead[k] = (CNT_W'(k) < count_ff) && (pri_ff[k] >= new_pri);

      always_comb begin
         val_in[k] = val_ff[k];
         pri_in[k] = pri_ff[k];
         if (cmd.do_insert && !ahead[k]) begin
            if (k == 0) begin
               val_in[k] = req_data.value;
               pri_in[k] = new_pri;
            end else if (ahead[(k > 0) ? k - 1 : 0]) begin
               val_in[k] = req_data.value;
               pri_in[k] = new_pri;
            end else begin
               val_in[k] = val_ff[(k > 0) ? k - 1 : 0];
               pri_in[k] = pri_ff[(k > 0) ? k - 1 : 0];
            end
         end else if (cmd.do_remove && (k < CAPACITY - 1)) begin
            val_in[k] = val_ff[(k < CAPACITY - 1) ? k + 1 : k];
            pri_in[k] = pri_ff[(k < CAPACITY - 1) ? k + 1 : k];
         end
      end

      always_ff @(posedge clock) begin
         val_ff[k] <= val_in[k];
         pri_ff[k] <= pri_in[k];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.do_insert) count_in = count_ff + CNT_W'(1);
      else if (cmd.do_remove) count_in = count_ff - CNT_W'(1);
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.status           = cmd.status;
         rsp_in.removed_value    = cmd.do_remove ? val_ff[0] : '0;
         rsp_in.removed_priority = cmd.do_remove ? front_pri : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue_unit.sv =====
// sorted priority queue: an insert or remove is done in the transfer cycle
// the result is valid in the cycle after the request transfer
// throughput: one item per cycle while rsp_ready is high, held by the single result register
// the compare row over all entries and the shift are combinational and finish in the transfer cycle
// reset clears the entry count and the result valid; entries are not cleared
`default_nettype none
module sorted_priority_queue_unit #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output spq_pkg::rsp_type      rsp_data
);
   import spq_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type dp_stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_data.mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .dp_stat  (dp_stat),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ===== test/tb_sorted_priority_queue_unit.sv =====
// testbench for the sorted priority queue: random and directed transfers checked against a model
`timescale 1ns / 1ps
module tb_sorted_priority_queue_unit;
   import spq_pkg::*;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int STALL_LIMIT   = 1000;
   localparam int HOLD_CYCLES   = 80;
   localparam int RANDOM_OPS    = 580;

   typedef struct {
      req_type op;
      bit      wait_idle;
   } stim_entry_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_entry_type ops_to_send[$];
   rsp_type        pending_outcomes[$];

   logic signed [VALUE_W-1:0] held_values [CAPACITY];
   logic [REQ_PRI_W-1:0]      held_prios  [CAPACITY];
   int                        held_count = 0;

   int unsigned reqs_taken   = 0;
   int unsigned rsps_taken   = 0;
   int unsigned next_hold_at = 120;
   int          hold_left    = 0;
   int          stall_cycles = 0;
   int          mismatches   = 0;
   logic        quiet;

   sorted_priority_queue_unit #(
      .CAPACITY     (CAPACITY),
      .PRIORITY_BITS(PRIORITY_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial forever #5 clock = ~clock;

   assign quiet = (reqs_taken >= 250) && (reqs_taken < 370);

   function automatic rsp_type queue_outcome(req_type op);
      rsp_type              res;
      logic [REQ_PRI_W-1:0] pri;
      int                   pos;
      res = '0;
      pri = op.priority_req & REQ_PRI_W'((1 << PRIORITY_BITS) - 1);
      if (op.mode == MODE_INSERT) begin
         if (held_count >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            pos = held_count;
            for (int k = 0; k < held_count; k++) begin
               if (pos == held_count && held_prios[k] < pri) pos = k;
            end
            for (int k = held_count; k > pos; k--) begin
               held_values[k] = held_values[k-1];
               held_prios[k]  = held_prios[k-1];
            end
            held_values[pos] = op.value;
            held_prios[pos]  = pri;
            held_count++;
            res.status = STATUS_INSERTED;
         end
      end else if (held_count == 0) begin
         res.status = STATUS_UNDERFLOW;
      end else begin
         res.status           = STATUS_REMOVED;
         res.removed_value    = held_values[0];
         res.removed_priority = held_prios[0];
         for (int k = 1; k < held_count; k++) begin
            held_values[k-1] = held_values[k];
            held_prios[k-1]  = held_prios[k];
         end
         held_count--;
      end
      return res;
   endfunction

   task automatic add_op(logic mode, logic signed [VALUE_W-1:0] value,
                         logic [REQ_PRI_W-1:0] prio, bit wait_idle);
      stim_entry_type e;
      e.op.mode         = mode;
      e.op.value        = value;
      e.op.priority_req = prio;
      e.wait_idle       = wait_idle;
      ops_to_send.push_back(e);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [REQ_PRI_W-1:0] pick_prio();
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return REQ_PRI_W'($urandom_range(0, 3));
         endcase
      end
      return REQ_PRI_W'($urandom_range(0, 255));
   endfunction

   // driver
   always @(posedge clock) begin
      stim_entry_type nxt;
      bit             drained;
      bit             send;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         drained = 1'b0;
         if (req_valid && req_ready) begin
            pending_outcomes.push_back(queue_outcome(req_data));
            reqs_taken <= reqs_taken + 1;
         end else if (!req_valid) begin
            drained = (reqs_taken == rsps_taken);
         end
         if (!req_valid || req_ready) begin
            send = (ops_to_send.size() != 0) && (quiet || $urandom_range(0, 99) >= 15);
            if (send && ops_to_send[0].wait_idle && !drained) send = 1'b0;
            if (send) begin
               nxt = ops_to_send.pop_front();
               req_valid <= 1'b1;
               req_data  <= nxt.op;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver with a long hold-off to back up the queue
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (reqs_taken >= next_hold_at) begin
         rsp_ready    <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + 300;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 15);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         rsps_taken <= rsps_taken + 1;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: status %0d value %0d priority %0d",
                        rsp_data.status, rsp_data.removed_value, rsp_data.removed_priority);
         end else begin
            exp = pending_outcomes.pop_front();
            if (rsp_data.status !== exp.status ||
                rsp_data.removed_value !== exp.removed_value ||
                rsp_data.removed_priority !== exp.removed_priority) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at result %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                           rsps_taken, exp.status, exp.removed_value, exp.removed_priority,
                           rsp_data.status, rsp_data.removed_value,
                           rsp_data.removed_priority);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", stall_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int n;
      int seg;
      int seg_len;
      int bias;
      // empty remove, extremes, equal priorities, fill, full insert, removes
      add_op(MODE_REMOVE, 32'sh1234_5678, 8'hff, 1'b0);
      add_op(MODE_INSERT, 32'sh7fff_ffff, 8'h00, 1'b0);
      add_op(MODE_INSERT, 32'sh8000_0000, 8'hff, 1'b0);
      add_op(MODE_INSERT, 32'sh0000_0000, 8'hff, 1'b0);
      add_op(MODE_INSERT, -1, 8'h80, 1'b0);
      add_op(MODE_INSERT, 32'sh0000_0001, 8'h00, 1'b0);
      for (int k = 0; k < 11; k++) begin
         case (k % 3)
            0: add_op(MODE_INSERT, $urandom, 8'h80, 1'b0);
            1: add_op(MODE_INSERT, $urandom, 8'h01, 1'b0);
            default: add_op(MODE_INSERT, $urandom, 8'hfe, 1'b0);
         endcase
      end
      add_op(MODE_INSERT, -1, 8'hff, 1'b0);
      for (int k = 0; k < 4; k++) add_op(MODE_REMOVE, $urandom, REQ_PRI_W'($urandom), 1'b0);

      n   = 0;
      seg = 0;
      while (n < RANDOM_OPS) begin
         seg_len = $urandom_range(10, 40);
         case ($urandom_range(0, 2))
            0: bias = 15;
            1: bias = 50;
            default: bias = 85;
         endcase
         for (int k = 0; k < seg_len && n < RANDOM_OPS; k++) begin
            add_op(($urandom_range(0, 99) < bias) ? MODE_INSERT : MODE_REMOVE,
                   pick_value(), pick_prio(), (k == 0) && (seg % 6 == 0));
            n++;
         end
         seg++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (ops_to_send.size() != 0 || req_valid || reqs_taken != rsps_taken)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
